// ----- rtl/ict_pkg.sv -----
// Shared widths, types and status structs of the in-circle / orientation test pipeline.
`timescale 1ns / 1ps

package ict_pkg;

	// Coordinate width of every input field
	localparam int COORD_BITS = 16;

	// Derived widths of the exact arithmetic
	localparam int DIFF_W  = COORD_BITS + 1;          // coordinate difference
	localparam int PROD_W  = 2 * DIFF_W;              // product of two differences
	localparam int LIFT_W  = 2 * COORD_BITS + 2;      // unsigned lifted term dx*dx + dy*dy
	localparam int MINOR_W = 2 * COORD_BITS + 3;      // 2x2 minor and orientation value
	localparam int LO_W    = (LIFT_W + 1) / 2;        // low slice of the lifted term
	localparam int HI_W    = LIFT_W - LO_W;           // high slice of the lifted term
	localparam int PP_LO_W = MINOR_W + LO_W + 1;      // partial product, low slice
	localparam int PP_HI_W = MINOR_W + HI_W + 1;      // partial product, high slice
	localparam int TERM_W  = MINOR_W + LIFT_W;        // full lifted * minor product
	localparam int DET_W   = TERM_W + 2;              // sum of three terms

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]     diff_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic        [LIFT_W-1:0]     lifted_t;
	typedef logic signed [MINOR_W-1:0]    minor_t;
	typedef logic signed [TERM_W-1:0]     term_t;

	// Lifted terms, minors and winding sign handed from the front end to the determinant
	typedef struct packed {
		lifted_t al;
		lifted_t bl;
		lifted_t cl;
		minor_t  mbc;
		minor_t  mac;
		minor_t  mab;
		logic    wind_pos;
		logic    wind_neg;
	} lift_t;

	// Occupancy of the first two determinant stages
	typedef struct packed {
		logic v_s4;
		logic v_s5;
	} det_occ_t;

endpackage

// ----- rtl/ict_query_if.sv -----
// Request channel carrying a triangle and a query point.
`timescale 1ns / 1ps

interface ict_query_if;
	logic           valid;
	logic           ready;
	ict_pkg::coord_t vert_a_x;
	ict_pkg::coord_t vert_a_y;
	ict_pkg::coord_t vert_b_x;
	ict_pkg::coord_t vert_b_y;
	ict_pkg::coord_t vert_c_x;
	ict_pkg::coord_t vert_c_y;
	ict_pkg::coord_t query_x;
	ict_pkg::coord_t query_y;

	modport source (
		output valid, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
		       vert_c_x, vert_c_y, query_x, query_y,
		input  ready
	);
	modport sink (
		input  valid, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
		       vert_c_x, vert_c_y, query_x, query_y,
		output ready
	);
endinterface

// ----- rtl/ict_result_if.sv -----
// Result channel carrying the in-circle and winding flags.
`timescale 1ns / 1ps

interface ict_result_if;
	logic valid;
	logic ready;
	logic inside_circle;
	logic winding_ok;

	modport source (output valid, inside_circle, winding_ok, input ready);
	modport sink (input valid, inside_circle, winding_ok, output ready);
endinterface

// ----- rtl/ict_lift.sv -----
// Front end: differences, products and lifted terms / minors over three stages.
`timescale 1ns / 1ps

module ict_lift (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	output logic            in_rdy,
	input  ict_pkg::coord_t ax,
	input  ict_pkg::coord_t ay,
	input  ict_pkg::coord_t bx,
	input  ict_pkg::coord_t by,
	input  ict_pkg::coord_t cx,
	input  ict_pkg::coord_t cy,
	input  ict_pkg::coord_t qx,
	input  ict_pkg::coord_t qy,
	output logic            lift_vld,
	input  logic            lift_rdy,
	output ict_pkg::lift_t  lift
);

	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;

	// stage 1: differences
	ict_pkg::diff_t adx_s1, ady_s1, bdx_s1, bdy_s1, cdx_s1, cdy_s1;
	ict_pkg::diff_t wbx_s1, wby_s1, wcx_s1, wcy_s1;

	// stage 2: products
	ict_pkg::prod_t sq_ax_s2, sq_ay_s2, sq_bx_s2, sq_by_s2, sq_cx_s2, sq_cy_s2;
	ict_pkg::prod_t bc1_s2, bc2_s2, ac1_s2, ac2_s2, ab1_s2, ab2_s2;
	ict_pkg::prod_t w1_s2, w2_s2;

	// stage 3: lifted terms, minors, winding sign
	ict_pkg::lift_t lift_s3;

	ict_pkg::prod_t sq_ax, sq_ay, sq_bx, sq_by, sq_cx, sq_cy;
	ict_pkg::prod_t bc1, bc2, ac1, ac2, ab1, ab2, w1, w2;
	ict_pkg::minor_t wind;
	ict_pkg::lift_t lift_next;

	// stall chain: a stage moves when empty or when its successor moves
	assign adv3     = !v_s3 || lift_rdy;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_rdy   = adv1;
	assign lift_vld = v_s3;
	assign lift     = lift_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_vld;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (adv1) begin
			adx_s1 <= ict_pkg::diff_t'(ax) - ict_pkg::diff_t'(qx);
			ady_s1 <= ict_pkg::diff_t'(ay) - ict_pkg::diff_t'(qy);
			bdx_s1 <= ict_pkg::diff_t'(bx) - ict_pkg::diff_t'(qx);
			bdy_s1 <= ict_pkg::diff_t'(by) - ict_pkg::diff_t'(qy);
			cdx_s1 <= ict_pkg::diff_t'(cx) - ict_pkg::diff_t'(qx);
			cdy_s1 <= ict_pkg::diff_t'(cy) - ict_pkg::diff_t'(qy);
			wbx_s1 <= ict_pkg::diff_t'(bx) - ict_pkg::diff_t'(ax);
			wby_s1 <= ict_pkg::diff_t'(by) - ict_pkg::diff_t'(ay);
			wcx_s1 <= ict_pkg::diff_t'(cx) - ict_pkg::diff_t'(ax);
			wcy_s1 <= ict_pkg::diff_t'(cy) - ict_pkg::diff_t'(ay);
		end
	end

	// products of differences, exact in PROD_W bits
	always_comb begin
		sq_ax = adx_s1 * adx_s1;
		sq_ay = ady_s1 * ady_s1;
		sq_bx = bdx_s1 * bdx_s1;
		sq_by = bdy_s1 * bdy_s1;
		sq_cx = cdx_s1 * cdx_s1;
		sq_cy = cdy_s1 * cdy_s1;
		bc1   = bdx_s1 * cdy_s1;
		bc2   = cdx_s1 * bdy_s1;
		ac1   = adx_s1 * cdy_s1;
		ac2   = cdx_s1 * ady_s1;
		ab1   = adx_s1 * bdy_s1;
		ab2   = bdx_s1 * ady_s1;
		w1    = wbx_s1 * wcy_s1;
		w2    = wcx_s1 * wby_s1;
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			sq_ax_s2 <= sq_ax;
			sq_ay_s2 <= sq_ay;
			sq_bx_s2 <= sq_bx;
			sq_by_s2 <= sq_by;
			sq_cx_s2 <= sq_cx;
			sq_cy_s2 <= sq_cy;
			bc1_s2   <= bc1;
			bc2_s2   <= bc2;
			ac1_s2   <= ac1;
			ac2_s2   <= ac2;
			ab1_s2   <= ab1;
			ab2_s2   <= ab2;
			w1_s2    <= w1;
			w2_s2    <= w2;
		end
	end

	// squares are never negative, so their bits add as unsigned without overflow
	always_comb begin
		lift_next.al  = ict_pkg::lifted_t'(sq_ax_s2) + ict_pkg::lifted_t'(sq_ay_s2);
		lift_next.bl  = ict_pkg::lifted_t'(sq_bx_s2) + ict_pkg::lifted_t'(sq_by_s2);
		lift_next.cl  = ict_pkg::lifted_t'(sq_cx_s2) + ict_pkg::lifted_t'(sq_cy_s2);
		lift_next.mbc = ict_pkg::minor_t'(bc1_s2) - ict_pkg::minor_t'(bc2_s2);
		lift_next.mac = ict_pkg::minor_t'(ac1_s2) - ict_pkg::minor_t'(ac2_s2);
		lift_next.mab = ict_pkg::minor_t'(ab1_s2) - ict_pkg::minor_t'(ab2_s2);
		wind          = ict_pkg::minor_t'(w1_s2) - ict_pkg::minor_t'(w2_s2);
		lift_next.wind_neg = wind[ict_pkg::MINOR_W-1];
		lift_next.wind_pos = !wind[ict_pkg::MINOR_W-1] && (|wind);
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			lift_s3 <= lift_next;
		end
	end

endmodule

// ----- rtl/ict_term_mul.sv -----
// Lifted term times minor, split into two registered partial products.
`timescale 1ns / 1ps

module ict_term_mul (
	input  logic             clk,
	input  logic             en,
	input  ict_pkg::lifted_t lifted,
	input  ict_pkg::minor_t  minor,
	output ict_pkg::term_t   term
);

	logic signed [ict_pkg::PP_LO_W-1:0] lo_pp, lo_pp_s4;
	logic signed [ict_pkg::PP_HI_W-1:0] hi_pp, hi_pp_s4;
	logic signed [ict_pkg::LO_W:0]      lo_op;
	logic signed [ict_pkg::HI_W:0]      hi_op;
	ict_pkg::term_t                     lo_ext, hi_ext;

	// unsigned slices get a zero sign bit so the products stay signed
	assign lo_op = {1'b0, lifted[ict_pkg::LO_W-1:0]};
	assign hi_op = {1'b0, lifted[ict_pkg::LIFT_W-1:ict_pkg::LO_W]};
	assign lo_pp = minor * lo_op;
	assign hi_pp = minor * hi_op;

	always_ff @(posedge clk) begin
		if (en) begin
			lo_pp_s4 <= lo_pp;
			hi_pp_s4 <= hi_pp;
		end
	end

	// recombine: high slice weighted by 2^LO_W
	assign lo_ext = {{(ict_pkg::TERM_W-ict_pkg::PP_LO_W){lo_pp_s4[ict_pkg::PP_LO_W-1]}}, lo_pp_s4};
	assign hi_ext = {{(ict_pkg::TERM_W-ict_pkg::PP_HI_W){hi_pp_s4[ict_pkg::PP_HI_W-1]}}, hi_pp_s4};
	assign term   = (hi_ext <<< ict_pkg::LO_W) + lo_ext;

endmodule

// ----- rtl/ict_det.sv -----
// Back end: lifted 3x3 determinant over three stages and the sign decision.
`timescale 1ns / 1ps

module ict_det (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              lift_vld,
	output logic              lift_rdy,
	input  ict_pkg::lift_t    lift,
	output logic              res_vld,
	input  logic              res_rdy,
	output logic              inside_circle,
	output logic              winding_ok,
	output ict_pkg::det_occ_t occ
);

	logic v_s4, v_s5, v_s6;
	logic adv4, adv5, adv6;

	logic wpos_s4, wneg_s4, wpos_s5, wneg_s5;
	ict_pkg::term_t ta, tb, tc;
	ict_pkg::term_t ta_s5, tb_s5, tc_s5;
	logic inside_s6, wok_s6;

	logic [ict_pkg::DET_W-1:0] d3;
	logic d_neg, d_pos;

	assign adv6     = !v_s6 || res_rdy;
	assign adv5     = !v_s5 || adv6;
	assign adv4     = !v_s4 || adv5;
	assign lift_rdy = adv4;
	assign res_vld  = v_s6;
	assign inside_circle = inside_s6;
	assign winding_ok    = wok_s6;
	assign occ.v_s4 = v_s4;
	assign occ.v_s5 = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv4) v_s4 <= lift_vld;
			if (adv5) v_s5 <= v_s4;
			if (adv6) v_s6 <= v_s5;
		end
	end

	// stage 4: partial products, one unit per determinant term
	ict_term_mul u_mul_a (.clk(clk), .en(adv4), .lifted(lift.al), .minor(lift.mbc), .term(ta));
	ict_term_mul u_mul_b (.clk(clk), .en(adv4), .lifted(lift.bl), .minor(lift.mac), .term(tb));
	ict_term_mul u_mul_c (.clk(clk), .en(adv4), .lifted(lift.cl), .minor(lift.mab), .term(tc));

	always_ff @(posedge clk) begin
		if (adv4) begin
			wpos_s4 <= lift.wind_pos;
			wneg_s4 <= lift.wind_neg;
		end
	end

	// stage 5: recombined full terms
	always_ff @(posedge clk) begin
		if (adv5) begin
			ta_s5   <= ta;
			tb_s5   <= tb;
			tc_s5   <= tc;
			wpos_s5 <= wpos_s4;
			wneg_s5 <= wneg_s4;
		end
	end

	// stage 6: the 3x3 sum has the opposite sign of the 4x4 determinant,
	// so inside means the same sign as the orientation here
	always_comb begin
		d3 = ict_pkg::DET_W'(ta_s5) - ict_pkg::DET_W'(tb_s5) + ict_pkg::DET_W'(tc_s5);
		d_neg = d3[ict_pkg::DET_W-1];
		d_pos = !d3[ict_pkg::DET_W-1] && (|d3);
	end

	always_ff @(posedge clk) begin
		if (adv6) begin
			inside_s6 <= (wpos_s5 && d_pos) || (wneg_s5 && d_neg);
			wok_s6    <= !wneg_s5;
		end
	end

endmodule

// ----- rtl/incircle_orientation_test.sv -----
// Top level of the in-circle / orientation test pipeline.
// Usage:
//   item   : request channel, one triangle (vert_a/b/c) and one query point per
//            request, signed grid coordinates; taken when valid and ready are high.
//   result : one response per request, in order: inside_circle is 1 when the
//            query lies strictly inside the circumcircle, winding_ok is 1 when the
//            orientation determinant is zero or positive.
// Pipeline: six register stages (three front-end stages of differences,
//   products and minors; three back-end stages of split multiplies,
//   recombination and the wide determinant sum with sign decision).
// Throughput: one request per cycle unless stalled (fully pipelined multipliers).
// Stalls: a full stage holds while its successor holds, so bubbles close up and
//   item.ready drops only when all six stages hold results and result.ready is low.
// Reset: arst_n clears all stage valid bits; the pipeline is empty afterwards and
//   item.ready is high in the first cycle.
`timescale 1ns / 1ps

module incircle_orientation_test (
	input  logic          clk,
	input  logic          arst_n,
	ict_query_if.sink     item,
	ict_result_if.source  result
);

	logic              lift_vld;
	logic              lift_rdy;
	ict_pkg::lift_t    lift;
	ict_pkg::det_occ_t occ;

	// front end: differences, products, lifted terms and minors
	ict_lift u_lift (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (item.valid),
		.in_rdy   (item.ready),
		.ax       (item.vert_a_x),
		.ay       (item.vert_a_y),
		.bx       (item.vert_b_x),
		.by       (item.vert_b_y),
		.cx       (item.vert_c_x),
		.cy       (item.vert_c_y),
		.qx       (item.query_x),
		.qy       (item.query_y),
		.lift_vld (lift_vld),
		.lift_rdy (lift_rdy),
		.lift     (lift)
	);

	// back end: determinant and sign decision
	ict_det u_det (
		.clk           (clk),
		.arst_n        (arst_n),
		.lift_vld      (lift_vld),
		.lift_rdy      (lift_rdy),
		.lift          (lift),
		.res_vld       (result.valid),
		.res_rdy       (result.ready),
		.inside_circle (result.inside_circle),
		.winding_ok    (result.winding_ok),
		.occ           (occ)
	);

`ifndef ASSERT_OFF
	// back-pressure at the input only when the whole pipeline is full and stalled
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (result.valid && !result.ready))
		else $error("request stalled while the result side was not blocked");

	// a result appears only after determinant stage 5 held one
	a_result_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(occ.v_s5))
		else $error("result valid without an occupied determinant stage");

	// the handoff between the front and back ends keeps a stalled request intact
	a_lift_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(lift_vld && !lift_rdy) |=> (lift_vld && $stable(lift)))
		else $error("front-end output changed while stalled");
`endif

endmodule
